@@ src/bbc_pkg.sv @@
// ----------------------------------------------------------------------------
// bbc_pkg: shared types and constants for the block buffer cache directory
// Opcodes, status codes, entry record layout and sequencer states.
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam int unsigned DevW   = 16;
  localparam int unsigned BlkW   = 32;
  localparam int unsigned CntW   = 8;
  localparam int unsigned StampW = 32;
  localparam int unsigned SlotW  = 5;

  localparam logic [CntW-1:0] CountMax = 8'hff;

  typedef enum logic [1:0] {
    OP_GET     = 2'd0,
    OP_RELEASE = 2'd1,
    OP_PIN     = 2'd2,
    OP_UNPIN   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic              valid;
    logic [StampW-1:0] stamp;
    logic [CntW-1:0]   count;
    logic [BlkW-1:0]   blk;
    logic [DevW-1:0]   dev;
  } rec_t;

  localparam int unsigned RecW = $bits(rec_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_SCAN,
    S_VICTIM,
    S_READ,
    S_MODIFY,
    S_OUT
  } state_e;

endpackage

@@ src/bbc_ram.sv @@
// ----------------------------------------------------------------------------
// bbc_ram: generic single-port synchronous RAM
// One write or read per cycle, read data registered.
// ----------------------------------------------------------------------------
module bbc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/block_buffer_cache_lru.sv @@
// Sequence: a get scans every entry through the RAM read pipeline, reads the victim,
// updates it and loads the output register, skipping the update with no free entry;
// release/pin/unpin read, update and load, skipping the update when out of range.
// One item at a time; the next beat is taken the cycle after the result is loaded
// into the output register; a result that finds it still full waits in S_OUT.
// Reset: a clearing pass zeroes every RAM entry; no beat is taken during it.
// ----------------------------------------------------------------------------
// block_buffer_cache_lru: disk-block buffer cache directory with LRU recycle
// Tag lookup, reference counting and oldest-free victim search over one RAM.
// ----------------------------------------------------------------------------
module block_buffer_cache_lru #(
  parameter int unsigned ENTRIES = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // opcode[1:0], device[17:2], block_number[49:18], entry[54:50], now[86:55]
  input  logic [87:0]  s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // slot[4:0], needs_fill[5], status[7:6]
  output logic [7:0]   m_axis_tdata_o
);
  import bbc_pkg::*;

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] LastIdx = CW'(ENTRIES - 1);

  state_e state_q, state_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [1:0] op_q;
  logic [DevW-1:0] dev_q;
  logic [BlkW-1:0] blk_q;
  logic [SlotW-1:0] ent_q;
  logic [StampW-1:0] now_q;
  logic hit_q, hit_d, found_q, found_d;
  logic [AW-1:0] tgt_q, tgt_d;
  logic [StampW-1:0] old_q, old_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic fill_q, fill_d;
  logic [1:0] stat_q, stat_d;
  logic ovld_q, ovld_d;
  logic [SlotW-1:0] oslot_q;
  logic ofill_q;
  logic [1:0] ostat_q;
  logic out_ld;

  logic we;
  logic [AW-1:0] addr;
  rec_t wrec, rrec;
  logic [AW-1:0] rd_idx_q;
  logic rd_vld_q;
  logic in_range;

  bbc_ram #(.Width(RecW), .Depth(ENTRIES)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(wrec),
    .rdata_o(rrec)
  );

  assign in_range = ({1'b0, ent_q} < (SlotW+1)'(ENTRIES > 31 ? 32 : ENTRIES))
                    && (32'(ent_q) < 32'(ENTRIES));

  assign out_ld = (state_q == S_OUT) && (!ovld_q || m_axis_tready_i);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    hit_d   = hit_q;
    found_d = found_q;
    tgt_d   = tgt_q;
    old_d   = old_q;
    slot_d  = slot_q;
    fill_d  = fill_q;
    stat_d  = stat_q;
    ovld_d  = ovld_q;
    we      = 1'b0;
    addr    = idx_q[AW-1:0];
    wrec    = rrec;
    if (ovld_q && m_axis_tready_i) begin
      ovld_d = 1'b0;
    end
    case (state_q)
      S_CLEAR: begin
        we   = 1'b1;
        wrec = '0;
        idx_d = idx_q + 1'b1;
        if (idx_q == LastIdx) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          idx_d   = '0;
          hit_d   = 1'b0;
          found_d = 1'b0;
          tgt_d   = '0;
          if (s_axis_tdata_i[1:0] == OP_GET) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_SCAN: begin
        if (idx_q != CW'(ENTRIES)) begin
          idx_d = idx_q + 1'b1;
        end
        if (rd_vld_q && !hit_q) begin
          if (rrec.dev == dev_q && rrec.blk == blk_q) begin
            hit_d = 1'b1;
            tgt_d = rd_idx_q;
          end else if (rrec.count == '0 && (!found_q || rrec.stamp < old_q)) begin
            found_d = 1'b1;
            old_d   = rrec.stamp;
            tgt_d   = rd_idx_q;
          end
        end
        if (rd_vld_q && rd_idx_q == LastIdx[AW-1:0]) begin
          state_d = S_VICTIM;
        end
      end
      S_VICTIM: begin
        addr = tgt_q;
        if (!hit_q && !found_q) begin
          slot_d  = '0;
          fill_d  = 1'b0;
          stat_d  = ST_NO_FREE;
          state_d = S_OUT;
        end else begin
          state_d = S_MODIFY;
        end
      end
      S_READ: begin
        addr = AW'(ent_q);
        tgt_d = AW'(ent_q);
        slot_d = ent_q;
        fill_d = 1'b0;
        stat_d = ST_OK;
        if (in_range) begin
          state_d = S_MODIFY;
        end else begin
          state_d = S_OUT;
        end
      end
      S_MODIFY: begin
        addr    = tgt_q;
        state_d = S_OUT;
        stat_d  = ST_OK;
        fill_d  = 1'b0;
        slot_d  = SlotW'(tgt_q);
        case (op_q)
          OP_GET: begin
            we = 1'b1;
            wrec.stamp = now_q;
            wrec.valid = 1'b1;
            if (hit_q) begin
              fill_d = !rrec.valid;
              if (rrec.count != CountMax) begin
                wrec.count = rrec.count + 1'b1;
              end
            end else begin
              fill_d = 1'b1;
              wrec.dev = dev_q;
              wrec.blk = blk_q;
              wrec.count = CntW'(1);
            end
          end
          OP_PIN: begin
            we = 1'b1;
            if (rrec.count != CountMax) begin
              wrec.count = rrec.count + 1'b1;
            end
          end
          default: begin
            if (rrec.count == '0) begin
              stat_d = ST_UNDERFLOW;
            end else begin
              we = 1'b1;
              wrec.count = rrec.count - 1'b1;
              if (op_q == OP_RELEASE && rrec.count == CntW'(1)) begin
                wrec.stamp = now_q;
              end
            end
          end
        endcase
      end
      S_OUT: begin
        if (out_ld) begin
          ovld_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      idx_q    <= '0;
      ovld_q   <= 1'b0;
      rd_vld_q <= 1'b0;
      hit_q    <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      ovld_q   <= ovld_d;
      rd_vld_q <= (state_q == S_SCAN) && (idx_q != CW'(ENTRIES));
      hit_q    <= hit_d;
      found_q  <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= addr;
    tgt_q    <= tgt_d;
    old_q    <= old_d;
    slot_q   <= slot_d;
    fill_q   <= fill_d;
    stat_q   <= stat_d;
    if (out_ld) begin
      oslot_q <= slot_q;
      ofill_q <= fill_q;
      ostat_q <= stat_q;
    end
    if (state_q == S_IDLE && s_axis_tvalid_i) begin
      op_q  <= s_axis_tdata_i[1:0];
      dev_q <= s_axis_tdata_i[17:2];
      blk_q <= s_axis_tdata_i[49:18];
      ent_q <= s_axis_tdata_i[54:50];
      now_q <= s_axis_tdata_i[86:55];
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = ovld_q;
  assign m_axis_tdata_o  = {ostat_q, ofill_q, oslot_q};

  property p_busy_no_ready;
    @(posedge clk_i) disable iff (!rst_ni)
      (state_q != S_IDLE) |-> !s_axis_tready_o;
  endproperty
  a_busy_no_ready: assert property (p_busy_no_ready) else $error("ready while busy");

  property p_out_after;
    @(posedge clk_i) disable iff (!rst_ni)
      $rose(m_axis_tvalid_o) |-> $past(state_q == S_OUT);
  endproperty
  a_out_after: assert property (p_out_after) else $error("result without sequence");

  property p_fill_ok;
    @(posedge clk_i) disable iff (!rst_ni)
      (m_axis_tvalid_o && ofill_q) |-> (ostat_q == ST_OK);
  endproperty
  a_fill_ok: assert property (p_fill_ok) else $error("fill with error status");

endmodule

@@ verif/block_buffer_cache_lru_chk.sv @@
// ----------------------------------------------------------------------------
// block_buffer_cache_lru_chk: result checker for the buffer cache directory
// Watches both stream channels, predicts each result from its own copy of
// the directory and compares every output beat field by field.
// ----------------------------------------------------------------------------
module block_buffer_cache_lru_chk #(
  parameter int unsigned ENTRIES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [87:0] s_axis_tdata_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [7:0]  m_axis_tdata_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import bbc_pkg::*;

  typedef struct packed {
    status_e          status;
    logic             fill;
    logic [SlotW-1:0] slot;
  } resp_t;

  logic [DevW-1:0]   tag_dev   [ENTRIES];
  logic [BlkW-1:0]   tag_blk   [ENTRIES];
  logic [CntW-1:0]   refs      [ENTRIES];
  logic [StampW-1:0] stamp     [ENTRIES];
  logic              filled    [ENTRIES];
  resp_t             resp_q    [$];
  int                fails;

  assign fail_count_o = fails;
  assign pending_o    = resp_q.size();

  function automatic resp_t cache_access(logic [87:0] d);
    op_e               op;
    logic [DevW-1:0]   dev;
    logic [BlkW-1:0]   blk;
    logic [4:0]        e;
    logic [StampW-1:0] now;
    logic [StampW-1:0] oldest;
    int                victim;
    bit                found;
    resp_t             r;
    op  = op_e'(d[1:0]);
    dev = d[17:2];
    blk = d[49:18];
    e   = d[54:50];
    now = d[86:55];
    r   = '{status: ST_OK, fill: 1'b0, slot: e};
    found = 0;
    oldest = '0;
    victim = 0;
    if (op == OP_GET) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (tag_dev[i] == dev && tag_blk[i] == blk) begin
          if (refs[i] != CountMax) refs[i]++;
          stamp[i] = now;
          r.fill = !filled[i];
          filled[i] = 1'b1;
          r.slot = i[SlotW-1:0];
          return r;
        end
      end
      for (int i = 0; i < ENTRIES; i++) begin
        if (refs[i] == 0 && (!found || stamp[i] < oldest)) begin
          found = 1;
          oldest = stamp[i];
          victim = i;
        end
      end
      if (!found) begin
        r = '{status: ST_NO_FREE, fill: 1'b0, slot: '0};
        return r;
      end
      tag_dev[victim] = dev;
      tag_blk[victim] = blk;
      refs[victim] = 1;
      stamp[victim] = now;
      filled[victim] = 1'b1;
      r.slot = victim[SlotW-1:0];
      r.fill = 1'b1;
      return r;
    end
    if (e >= ENTRIES) return r;
    if (op == OP_PIN) begin
      if (refs[e] != CountMax) refs[e]++;
      return r;
    end
    if (refs[e] == 0) begin
      r.status = ST_UNDERFLOW;
      return r;
    end
    refs[e]--;
    if (op == OP_RELEASE && refs[e] == 0) stamp[e] = now;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    resp_t got;
    resp_t want;
    int    nerr;
    nerr = 0;
    if (!rst_ni) begin
      fails <= 0;
      resp_q.delete();
      for (int i = 0; i < ENTRIES; i++) begin
        tag_dev[i] = '0;
        tag_blk[i] = '0;
        refs[i]    = '0;
        stamp[i]   = '0;
        filled[i]  = 1'b0;
      end
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = resp_t'(m_axis_tdata_i);
        if (resp_q.size() == 0) begin
          $error("unexpected result beat %h", m_axis_tdata_i);
          nerr++;
        end else begin
          want = resp_q.pop_front();
          if (got.slot != want.slot) begin
            $error("slot: expected %0d actual %0d", want.slot, got.slot);
            nerr++;
          end
          if (got.fill != want.fill) begin
            $error("needs_fill: expected %0d actual %0d", want.fill, got.fill);
            nerr++;
          end
          if (got.status != want.status) begin
            $error("status: expected %0d actual %0d", want.status, got.status);
            nerr++;
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) resp_q.push_back(cache_access(s_axis_tdata_i));
      fails <= fails + nerr;
    end
  end
endmodule

@@ verif/block_buffer_cache_lru_tb.sv @@
// ----------------------------------------------------------------------------
// block_buffer_cache_lru_tb: stimulus top for the buffer cache directory
// Directed corner cases then random get/release/pin/unpin traffic over a
// small working set of tags, with random idling and a long output stall.
// ----------------------------------------------------------------------------
module block_buffer_cache_lru_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bbc_pkg::*;

  localparam int unsigned Entries  = 32;
  localparam int unsigned MaxCycles = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [87:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  bit          stall_req = 0;
  bit          quiet = 0;

  always #5 clk_i = ~clk_i;

  block_buffer_cache_lru #(.ENTRIES(Entries)) u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready), .s_axis_tdata_i(s_tdata),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready), .m_axis_tdata_o(m_tdata)
  );

  block_buffer_cache_lru_chk #(.ENTRIES(Entries)) u_chk (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_i(s_tready), .s_axis_tdata_i(s_tdata),
    .m_axis_tvalid_i(m_tvalid), .m_axis_tready_i(m_tready), .m_axis_tdata_i(m_tdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MaxCycles) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (stall_req) m_tready <= 1'b0;
    else m_tready <= quiet || ($urandom_range(99) >= 6);
  end

  task automatic send(op_e op, logic [15:0] dev, logic [31:0] blk, logic [4:0] e,
                      logic [31:0] now);
    while (!quiet && $urandom_range(99) < 6) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tdata  <= {1'b0, now, e, blk, dev, op};
    s_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  logic [31:0] tick = 0;
  task automatic rand_item(int tags);
    int   k;
    op_e  op;
    k  = $urandom_range(99);
    op = k < 40 ? OP_GET : k < 70 ? OP_RELEASE : k < 85 ? OP_PIN : OP_UNPIN;
    tick += $urandom_range(3);
    if ($urandom_range(19) == 0) tick = $urandom;
    if ($urandom_range(9) == 0)
      send(op_e'($urandom_range(3)), 16'($urandom), $urandom, 5'($urandom), $urandom);
    else
      send(op, 16'($urandom_range(tags) ^ ($urandom_range(30) == 0 ? 16'hffff : 16'h0)),
           $urandom_range(tags) ^ ($urandom_range(30) == 0 ? 32'hffffffff : 32'h0),
           5'($urandom_range(Entries - 1)), tick);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // directed
    send(OP_GET, 16'h0, 32'h0, 5'd0, 32'h0);
    send(OP_GET, 16'h0, 32'h0, 5'd0, 32'hffffffff);
    send(OP_UNPIN, 16'h0, 32'h0, 5'd31, 32'h5);
    send(OP_RELEASE, 16'h0, 32'h0, 5'd31, 32'h5);
    send(OP_RELEASE, 16'h0, 32'h0, 5'd0, 32'h7);
    send(OP_RELEASE, 16'h0, 32'h0, 5'd0, 32'hffffffff);
    send(OP_GET, 16'hffff, 32'hffffffff, 5'd0, 32'h9);
    send(OP_PIN, 16'h0, 32'h0, 5'd5, 32'h0);
    send(OP_GET, 16'h0, 32'h0, 5'd5, 32'h1);
    send(OP_UNPIN, 16'h0, 32'h0, 5'd5, 32'h0);
    send(OP_UNPIN, 16'h0, 32'h0, 5'd5, 32'h0);
    for (int i = 0; i < 260; i++) send(OP_PIN, 16'h0, 32'h0, 5'd3, 32'h0);
    send(OP_GET, 16'h1234, 32'h0, 5'd0, 32'h2);
    for (int i = 0; i < 34; i++) send(OP_GET, 16'h77, i, 5'd0, 32'h10 + i);
    send(OP_RELEASE, 16'h0, 32'h0, 5'd9, 32'hffffffff);
    send(OP_GET, 16'hbeef, 32'h1, 5'd0, 32'h50);
    send(OP_GET, 16'h0, 32'h0, 5'd0, 32'h50);
    for (int i = 0; i < Entries; i++) send(OP_RELEASE, 16'h0, 32'h0, 5'(i), 32'h60);
    // random, with a long output stall partway
    fork
      begin
        #20000;
        @(negedge clk_i);
        stall_req = 1;
        repeat (400) @(negedge clk_i);
        stall_req = 0;
      end
    join_none
    for (int n = 0; n < 1060; n++) begin
      quiet = (n >= 600 && n < 800);
      rand_item(n < 700 ? 40 : 8);
    end
    s_tvalid <= 1'b0;
    quiet = 0;
    while (pending != 0) @(posedge clk_i);
    repeat (Entries + 10) @(posedge clk_i);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
